@@ sv/i2c_master_bit_engine_assert.svh @@
// Assertion macros for the I2C master bit engine.
// Needs signals clk and rst_n in the including module.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define I2CM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// Next-cycle implication, held off during reset
`define I2CM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`endif

@@ sv/i2cm_pkg.sv @@
// Shared types, constants and phase functions for the I2C master bit engine.
// No dependencies.
package i2cm_pkg;

    localparam int DELAY_WIDTH = 16;
    localparam int HALF_W      = 16;
    localparam int LIMIT_W     = 8;

    localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(5);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(250);

    // Largest half period the delay counter can hold
    localparam logic [HALF_W-1:0]  DLY_MAX = HALF_W'((64'd1 << DELAY_WIDTH) - 64'd1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_HALF_PERIOD = 1'b0,
        REG_ACK_TIMEOUT = 1'b1
    } reg_idx_e;

    // Command codes
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_WAIT_ACK  = 3'd4,
        CMD_SEND_ACK  = 3'd5,
        CMD_SEND_NACK = 3'd6,
        CMD_READ      = 3'd7
    } cmd_e;

    // Sequencer state
    typedef struct packed {
        cmd_e                   cmd;
        logic [3:0]             phase;
        logic [3:0]             bit_cnt;
        logic [7:0]             shift;
        logic [DELAY_WIDTH-1:0] dly;
        logic [LIMIT_W-1:0]     tmo;
        logic                   scl;
        logic                   sda;
        logic                   ack;
        logic                   rd_ack;
        logic [7:0]             rx;
    } seq_st_t;

    // One result transaction
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       nack;
    } res_t;

    // Idle, both lines released
    localparam seq_st_t SEQ_RESET = '{cmd: CMD_NONE, phase: 4'd0, bit_cnt: 4'd0,
                                      shift: 8'd0, dly: '0, tmo: '0, scl: 1'b1,
                                      sda: 1'b1, ack: 1'b0, rd_ack: 1'b0, rx: 8'd0};

    localparam res_t RES_RESET = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
                                   rx: 8'd0, nack: 1'b0};

    // Return to idle
    function automatic seq_st_t finish_cmd(seq_st_t s);
        seq_st_t r;
        r         = s;
        r.cmd     = CMD_NONE;
        r.phase   = 4'd0;
        r.bit_cnt = 4'd0;
        r.dly     = '0;
        return r;
    endfunction

    // Move to a phase and drive its line levels
    function automatic seq_st_t enter_phase(seq_st_t s, logic [3:0] ph);
        seq_st_t r;
        r       = s;
        r.phase = ph;
        r.dly   = '0;
        unique case (s.cmd)
            CMD_START:
            begin
                if (ph == 4'd0) begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else if (ph == 4'd1) begin
                    r.sda = 1'b0;
                end else begin
                    r.scl = 1'b0;
                    r     = finish_cmd(r);
                end
            end
            CMD_STOP:
            begin
                if (ph == 4'd0) begin
                    r.sda = 1'b0;
                    r.scl = 1'b1;
                end else if (ph == 4'd1) begin
                    r.sda = 1'b1;
                end else begin
                    r = finish_cmd(r);
                end
            end
            CMD_WRITE:
            begin
                if (ph == 4'd0) begin
                    r.scl   = 1'b0;
                    r.sda   = s.shift[7];
                    r.shift = {s.shift[6:0], 1'b0};
                end else if (ph == 4'd1) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                    r     = finish_cmd(r);
                end
            end
            CMD_WAIT_ACK:
            begin
                if (ph == 4'd0) begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else if (ph == 4'd1) begin
                    r.tmo = '0;
                end else if (ph == 4'd2) begin
                    r.sda = 1'b0;
                    r.scl = 1'b1;
                end else if (ph == 4'd3) begin
                    r.sda = 1'b1;
                end else begin
                    r = finish_cmd(r);
                end
            end
            CMD_SEND_ACK, CMD_SEND_NACK:
            begin
                if (ph == 4'd0) begin
                    r.sda = (s.cmd == CMD_SEND_NACK);
                end else if (ph == 4'd1) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                    r     = finish_cmd(r);
                end
            end
            CMD_READ:
            begin
                if (ph == 4'd0) begin
                    r.sda = 1'b1;
                    r.scl = 1'b0;
                end else if (ph == 4'd1) begin
                    r.scl = 1'b1;
                end else if (ph == 4'd2) begin
                    r.scl = 1'b0;
                    r.sda = !s.rd_ack;
                end else if (ph == 4'd3) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                    r.rx  = s.shift;
                    r     = finish_cmd(r);
                end
            end
            default:
            begin
                r = finish_cmd(r);
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/i2cm_core.sv @@
// Line sequencer state and its one-step update for the I2C master bit engine.
// Depends on i2cm_pkg.
module i2cm_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [2:0]                  func,
    input  logic [7:0]                  write_byte,
    input  logic                        ack_after_read,
    input  logic                        tick,
    input  logic                        sda_in,
    input  logic [i2cm_pkg::HALF_W-1:0]  half_period,
    input  logic [i2cm_pkg::LIMIT_W-1:0] ack_limit,
    output i2cm_pkg::res_t               res
);
    import i2cm_pkg::*;

    seq_st_t st_reg;
    seq_st_t st_next;

    logic [DELAY_WIDTH-1:0] dly_lim;
    logic [DELAY_WIDTH-1:0] dly_inc;
    logic [LIMIT_W:0]       tmo_inc;

    // Half-period limit, zero acts as one tick, oversize clamps to the counter range
    assign dly_lim = (half_period == '0)     ? DELAY_WIDTH'(1) :
                     (half_period > DLY_MAX) ? DELAY_WIDTH'(DLY_MAX) :
                                               DELAY_WIDTH'(half_period);
    assign dly_inc = st_reg.dly + DELAY_WIDTH'(1);
    assign tmo_inc = {1'b0, st_reg.tmo} + (LIMIT_W+1)'(1);

    // Next state for one transaction
    always_comb
    begin
        st_next = st_reg;
        if (st_reg.cmd == CMD_NONE) begin
            if (func != CMD_NONE) begin
                st_next.cmd     = cmd_e'(func);
                st_next.bit_cnt = 4'd0;
                st_next.tmo     = '0;
                st_next.shift   = (cmd_e'(func) == CMD_WRITE) ? write_byte : 8'd0;
                st_next.rd_ack  = ack_after_read;
                st_next         = enter_phase(st_next, 4'd0);
            end
        end else if (st_reg.cmd == CMD_WAIT_ACK && st_reg.phase == 4'd1) begin
            // Poll SDA for the acknowledge
            if (!sda_in) begin
                st_next.ack = 1'b0;
                st_next.scl = 1'b0;
                st_next     = finish_cmd(st_next);
            end else if (tick) begin
                if (tmo_inc > {1'b0, ack_limit}) begin
                    st_next.ack = 1'b1;
                    st_next.tmo = '0;
                    st_next     = enter_phase(st_next, 4'd2);
                end else begin
                    st_next.tmo = tmo_inc[LIMIT_W-1:0];
                end
            end
        end else if (tick) begin
            // Half-period delay count
            if (dly_inc >= dly_lim) begin
                st_next.dly = '0;
                if ((st_reg.cmd == CMD_WRITE || st_reg.cmd == CMD_READ)
                    && st_reg.phase == 4'd1) begin
                    if (st_reg.cmd == CMD_READ) begin
                        st_next.shift = {st_reg.shift[6:0], sda_in};
                    end
                    st_next.bit_cnt = st_reg.bit_cnt + 4'd1;
                    st_next = enter_phase(st_next,
                                          (st_next.bit_cnt < 4'd8) ? 4'd0 : 4'd2);
                end else begin
                    st_next = enter_phase(st_next, st_reg.phase + 4'd1);
                end
            end else begin
                st_next.dly = dly_inc;
            end
        end
    end

    // State register, advanced once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= SEQ_RESET;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

    // Result of this step
    assign res.scl  = st_next.scl;
    assign res.sda  = st_next.sda;
    assign res.busy = (st_next.cmd != CMD_NONE);
    assign res.done = (st_reg.cmd != CMD_NONE) && (st_next.cmd == CMD_NONE);
    assign res.rx   = st_next.rx;
    assign res.nack = st_next.ack;

endmodule

@@ sv/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: handshakes, config registers, result register.
// Depends on i2cm_pkg, i2cm_core and i2c_master_bit_engine_assert.svh.
//
//  channel  handshake              payload
//  in       in_valid / in_ready    func, write_byte, ack_after_read, tick, sda_in
//  out      out_valid / out_ready  scl_out, sda_out, busy_res, done_res, read_byte,
//                                  nack_status
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input per clock while in_ready is high; its result is registered, seen next cycle.
// The sequencer advances at most one phase per transaction, in a single registered step.
// in_ready drops only while a result is held and out_ready is low.
// Reset: idle, SCL and SDA released, half period 5 ticks, ACK timeout 250 ticks.
// cfg_ready is always high.
module i2c_master_bit_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   func,
    input  logic [7:0]                   write_byte,
    input  logic                         ack_after_read,
    input  logic                         tick,
    input  logic                         sda_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         scl_out,
    output logic                         sda_out,
    output logic                         busy_res,
    output logic                         done_res,
    output logic [7:0]                   read_byte,
    output logic                         nack_status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [i2cm_pkg::HALF_W-1:0]  cfg_data
);
    import i2cm_pkg::*;

    logic [HALF_W-1:0]  half_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               res_reg;
    res_t               res_next;
    logic               in_acc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_reg  <= HALF_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (reg_idx_e'(cfg_index))
                REG_HALF_PERIOD: half_reg  <= cfg_data;
                REG_ACK_TIMEOUT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         half_reg  <= half_reg;
            endcase
        end
    end

    i2cm_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (in_acc),
        .func           (func),
        .write_byte     (write_byte),
        .ack_after_read (ack_after_read),
        .tick           (tick),
        .sda_in         (sda_in),
        .half_period    (half_reg),
        .ack_limit      (limit_reg),
        .res            (res_next)
    );

    // Output valid: set on each input transaction, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_acc) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            res_reg       <= RES_RESET;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_acc) begin
                res_reg <= res_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_out     = res_reg.scl;
    assign sda_out     = res_reg.sda;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign read_byte   = res_reg.rx;
    assign nack_status = res_reg.nack;

    `include "i2c_master_bit_engine_assert.svh"

    // A finished command leaves the engine idle
    `I2CM_ASSERT_SAME(a_done_not_busy, out_valid_reg && res_reg.done, !res_reg.busy)
    // Every input transaction yields a result
    `I2CM_ASSERT_NEXT(a_acc_out_valid, in_acc, out_valid_reg)
    // A command accepted while idle is still running on the next result
    `I2CM_ASSERT_NEXT(a_start_busy, in_acc && !res_reg.busy && func != CMD_NONE, res_reg.busy)
    // Results change only on an input transaction
    `I2CM_ASSERT_NEXT(a_res_hold, !in_acc, $stable(res_reg))

endmodule

@@ tb/i2c_master_bit_engine_test.sv @@
// Testbench for the I2C master bit engine: directed and random command traffic,
// checked per accepted result against a behavioral sequencer model kept in this file.
// Depends on i2cm_pkg and i2c_master_bit_engine.
`timescale 1ns / 1ps

module i2c_master_bit_engine_test;

    import i2cm_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          func;
    logic [7:0]          write_byte;
    logic                ack_after_read;
    logic                tick;
    logic                sda_in;
    logic                out_valid;
    logic                out_ready;
    logic                scl_out;
    logic                sda_out;
    logic                busy_res;
    logic                done_res;
    logic [7:0]          read_byte;
    logic                nack_status;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [0:0]          cfg_index;
    logic [HALF_W-1:0]   cfg_data;

    // Model of the sequencer: configuration and state
    logic [HALF_W-1:0]   half_ticks  = HALF_RESET;
    logic [LIMIT_W-1:0]  ack_limit   = LIMIT_RESET;
    cmd_e                cur_cmd     = CMD_NONE;
    logic [3:0]          cur_phase   = 4'd0;
    logic [3:0]          bits_done   = 4'd0;
    logic [7:0]          shifter     = 8'd0;
    logic [15:0]         half_cnt    = 16'd0;
    logic [7:0]          ack_wait    = 8'd0;
    logic                scl_lvl     = 1'b1;
    logic                sda_lvl     = 1'b1;
    logic                nack_flag   = 1'b0;
    logic                ack_choice  = 1'b0;
    logic [7:0]          rx_hold     = 8'd0;
    logic                done_now    = 1'b0;

    res_t                pending_status[$];
    int                  fail_count   = 0;
    int                  sent_items   = 0;
    bit                  calm         = 1'b0;

    i2c_master_bit_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .write_byte     (write_byte),
        .ack_after_read (ack_after_read),
        .tick           (tick),
        .sda_in         (sda_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_out        (scl_out),
        .sda_out        (sda_out),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .read_byte      (read_byte),
        .nack_status    (nack_status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Command complete: back to idle
    function automatic void go_idle();
        cur_cmd   = CMD_NONE;
        cur_phase = 4'd0;
        bits_done = 4'd0;
        half_cnt  = 16'd0;
        done_now  = 1'b1;
    endfunction

    // Line levels set on entry to each phase of the running command
    function automatic void enter_step(logic [3:0] ph);
        cur_phase = ph;
        half_cnt  = 16'd0;
        case (cur_cmd)
            CMD_START:
            begin
                case (ph)
                    4'd0:    {scl_lvl, sda_lvl} = 2'b11;
                    4'd1:    sda_lvl = 1'b0;
                    default:
                    begin
                        scl_lvl = 1'b0;
                        go_idle();
                    end
                endcase
            end
            CMD_STOP:
            begin
                case (ph)
                    4'd0:    {scl_lvl, sda_lvl} = 2'b10;
                    4'd1:    sda_lvl = 1'b1;
                    default: go_idle();
                endcase
            end
            CMD_WRITE:
            begin
                case (ph)
                    4'd0:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = shifter[7];
                        shifter = {shifter[6:0], 1'b0};
                    end
                    4'd1:    scl_lvl = 1'b1;
                    default:
                    begin
                        scl_lvl = 1'b0;
                        go_idle();
                    end
                endcase
            end
            CMD_WAIT_ACK:
            begin
                case (ph)
                    4'd0:    {scl_lvl, sda_lvl} = 2'b11;
                    4'd1:    ack_wait = 8'd0;
                    4'd2:    {scl_lvl, sda_lvl} = 2'b10;
                    4'd3:    sda_lvl = 1'b1;
                    default: go_idle();
                endcase
            end
            CMD_SEND_ACK, CMD_SEND_NACK:
            begin
                case (ph)
                    4'd0:    sda_lvl = (cur_cmd == CMD_SEND_NACK);
                    4'd1:    scl_lvl = 1'b1;
                    default:
                    begin
                        scl_lvl = 1'b0;
                        go_idle();
                    end
                endcase
            end
            CMD_READ:
            begin
                case (ph)
                    4'd0:    {scl_lvl, sda_lvl} = 2'b01;
                    4'd1:    scl_lvl = 1'b1;
                    4'd2:
                    begin
                        scl_lvl = 1'b0;
                        sda_lvl = !ack_choice;
                    end
                    4'd3:    scl_lvl = 1'b1;
                    default:
                    begin
                        scl_lvl = 1'b0;
                        rx_hold = shifter;
                        go_idle();
                    end
                endcase
            end
            default: go_idle();
        endcase
    endfunction

    // One tick of the current half period; true when the half period is over.
    // A half period of zero behaves as one tick.
    function automatic bit half_elapsed(logic tk);
        logic [16:0] lim;
        lim = (half_ticks == '0) ? 17'd1 : {1'b0, half_ticks};
        if (!tk)
            return 1'b0;
        half_cnt = half_cnt + 16'd1;
        if ({1'b0, half_cnt} >= lim)
        begin
            half_cnt = 16'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the sequencer by one input transaction and return the status it shows
    function automatic res_t advance_sequencer(logic [2:0] f, logic [7:0] wb, logic aar,
                                               logic tk, logic sd);
        res_t r;
        done_now = 1'b0;
        if (cur_cmd == CMD_NONE)
        begin
            // new command only when idle; first levels driven at once
            if (cmd_e'(f) != CMD_NONE)
            begin
                cur_cmd    = cmd_e'(f);
                bits_done  = 4'd0;
                ack_wait   = 8'd0;
                shifter    = (cmd_e'(f) == CMD_WRITE) ? wb : 8'd0;
                ack_choice = aar;
                enter_step(4'd0);
            end
        end
        else if (cur_cmd == CMD_WAIT_ACK && cur_phase == 4'd1)
        begin
            // polling for ACK: SDA low wins, else count ticks toward timeout
            if (!sd)
            begin
                nack_flag = 1'b0;
                scl_lvl   = 1'b0;
                go_idle();
            end
            else if (tk)
            begin
                if ({1'b0, ack_wait} + 9'd1 > {1'b0, ack_limit})
                begin
                    nack_flag = 1'b1;
                    ack_wait  = 8'd0;
                    enter_step(4'd2);
                end
                else
                    ack_wait = ack_wait + 8'd1;
            end
        end
        else if (half_elapsed(tk))
        begin
            if ((cur_cmd == CMD_WRITE || cur_cmd == CMD_READ) && cur_phase == 4'd1)
            begin
                // end of SCL high: sample on reads, then next bit or ACK slot
                if (cur_cmd == CMD_READ)
                    shifter = {shifter[6:0], sd};
                bits_done = bits_done + 4'd1;
                enter_step((bits_done < 4'd8) ? 4'd0 : 4'd2);
            end
            else
                enter_step(cur_phase + 4'd1);
        end
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.busy = (cur_cmd != CMD_NONE);
        r.done = done_now;
        r.rx   = rx_hold;
        r.nack = nack_flag;
        return r;
    endfunction

    // Send one input transaction, possibly after an idle gap, and predict its status
    task automatic send_item(logic [2:0] f, logic [7:0] wb, logic aar, logic tk, logic sd);
        int   gap;
        res_t want;
        gap = 0;
        if (!calm && chance(25))
            gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        func           <= f;
        write_byte     <= wb;
        ack_after_read <= aar;
        tick           <= tk;
        sda_in         <= sd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = advance_sequencer(f, wb, aar, tk, sd);
        pending_status.push_back(want);
        sent_items++;
    endtask

    // Issue a command, then keep ticking until it has finished.
    // func on the filler transactions is random and must be ignored while busy.
    task automatic run_cmd(cmd_e c, logic [7:0] wb, logic aar, int tick_pct, int low_pct);
        send_item(c, wb, aar, chance(tick_pct), !chance(low_pct));
        while (cur_cmd != CMD_NONE)
            send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                      chance(tick_pct), !chance(low_pct));
    endtask

    // Register write, only once every pending status has come back
    task automatic write_reg(reg_idx_e idx, logic [HALF_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_HALF_PERIOD)
            half_ticks = val;
        else
            ack_limit = val[LIMIT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Short frame at reset configuration
    task automatic check_reset_defaults();
        run_cmd(CMD_NONE, 8'h00, 1'b0, 50, 50);
        run_cmd(CMD_NONE, 8'hFF, 1'b1, 50, 50);
        run_cmd(CMD_START, 8'h00, 1'b0, 100, 50);
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, 60, 50);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100, 20);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 100, 50);
    endtask

    // Write byte edge patterns, MSB first
    task automatic check_write_patterns();
        write_reg(REG_HALF_PERIOD, 16'd1);
        run_cmd(CMD_START, 8'h00, 1'b0, 100, 50);
        run_cmd(CMD_WRITE, 8'h00, 1'b0, 100, 50);
        run_cmd(CMD_WRITE, 8'hFF, 1'b1, 50, 50);
        run_cmd(CMD_WRITE, 8'h80, 1'b0, 100, 50);
        run_cmd(CMD_WRITE, 8'h01, 1'b0, 50, 50);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 100, 50);
    endtask

    // Read byte with all-ones, all-zeros and random data, then explicit ACK/NACK
    task automatic check_read_patterns();
        run_cmd(CMD_READ, 8'hFF, 1'b1, 100, 0);
        run_cmd(CMD_READ, 8'h00, 1'b0, 50, 100);
        run_cmd(CMD_READ, 8'h5A, 1'b1, 50, 50);
        run_cmd(CMD_SEND_ACK, 8'h00, 1'b0, 100, 50);
        run_cmd(CMD_SEND_NACK, 8'h00, 1'b0, 50, 50);
    endtask

    // ACK polling: zero limit, small limit, immediate ACK, largest limit
    task automatic check_ack_wait();
        write_reg(REG_ACK_TIMEOUT, 16'hFF00);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100, 0);
        write_reg(REG_ACK_TIMEOUT, 16'd1);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100, 0);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 50, 100);
        write_reg(REG_ACK_TIMEOUT, 16'h00FF);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100, 0);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 50, 5);
    endtask

    // Zero half period acts as a single tick
    task automatic check_zero_half_period();
        write_reg(REG_HALF_PERIOD, 16'd0);
        run_cmd(CMD_START, 8'h00, 1'b0, 50, 50);
        run_cmd(CMD_WRITE, 8'($urandom), 1'b0, 50, 50);
        run_cmd(CMD_SEND_NACK, 8'h00, 1'b0, 50, 50);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 50, 50);
    endtask

    // Largest half period: the start condition holds its levels over many ticks,
    // then the half period is shortened mid-command so it finishes
    task automatic check_max_half_period();
        calm = 1'b1;
        write_reg(REG_HALF_PERIOD, 16'hFFFF);
        send_item(CMD_START, 8'h00, 1'b0, 1'b1, 1'b1);
        repeat (40)
            send_item(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
        write_reg(REG_HALF_PERIOD, 16'd2);
        while (cur_cmd != CMD_NONE)
            send_item(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1);
        calm = 1'b0;
    endtask

    // Random traffic: mostly well-formed frames, some stray commands
    task automatic check_random_traffic();
        int          tick_pct;
        int          low_pct;
        int          r;
        logic [15:0] half_val;
        while (sent_items < 1050)
        begin
            calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            if (r == 0)
                half_val = 16'd0;
            else if (r < 15)
                half_val = 16'($urandom_range(1, 3));
            else if (r < 19)
                half_val = 16'($urandom_range(4, 8));
            else
                half_val = 16'($urandom_range(9, 20));
            write_reg(REG_HALF_PERIOD, half_val);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_ACK_TIMEOUT, {8'($urandom), 8'($urandom)});
            else
                write_reg(REG_ACK_TIMEOUT, {8'($urandom), 8'($urandom_range(0, 6))});
            case ($urandom_range(0, 2))
                0:       tick_pct = 100;
                1:       tick_pct = 50;
                default: tick_pct = 25;
            endcase
            repeat ($urandom_range(1, 2))
            begin
                low_pct = $urandom_range(3, 40);
                if ($urandom_range(0, 9) < 8)
                begin
                    // address, then data writes or reads, optional repeated start, stop
                    run_cmd(CMD_START, 8'($urandom), 1'($urandom), tick_pct, 50);
                    run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), tick_pct, 50);
                    run_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom), tick_pct, low_pct);
                    repeat ($urandom_range(0, 3))
                    begin
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), tick_pct, 50);
                                run_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
                                        tick_pct, low_pct);
                            end
                            1:
                            begin
                                run_cmd(CMD_READ, 8'($urandom), 1'($urandom), tick_pct, 50);
                            end
                            default:
                            begin
                                run_cmd(CMD_READ, 8'($urandom), 1'($urandom), tick_pct, 50);
                                run_cmd(chance(50) ? CMD_SEND_ACK : CMD_SEND_NACK,
                                        8'($urandom), 1'($urandom), tick_pct, 50);
                            end
                        endcase
                    end
                    if (chance(20))
                    begin
                        run_cmd(CMD_START, 8'($urandom), 1'($urandom), tick_pct, 50);
                        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), tick_pct, 50);
                        run_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom), tick_pct, low_pct);
                    end
                    run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), tick_pct, 50);
                end
                else
                begin
                    // broken frames: any command in any order, idle transactions too
                    repeat ($urandom_range(1, 6))
                        run_cmd(cmd_e'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                                tick_pct, low_pct);
                end
            end
        end
        calm = 1'b0;
    endtask

    // Result side stalls
    initial
    begin : ready_driver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && chance(25))
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge clk)
    begin
        res_t seen;
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.scl  = scl_out;
            seen.sda  = sda_out;
            seen.busy = busy_res;
            seen.done = done_res;
            seen.rx   = read_byte;
            seen.nack = nack_status;
            if (pending_status.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result ", $realtime,
                             "scl=%0b sda=%0b busy=%0b done=%0b rx=%02h nack=%0b",
                             seen.scl, seen.sda, seen.busy, seen.done, seen.rx,
                             seen.nack);
            end
            else
            begin
                want = pending_status.pop_front();
                if (seen.scl !== want.scl || seen.sda !== want.sda || seen.busy !== want.busy
                    || seen.done !== want.done || seen.rx !== want.rx
                    || seen.nack !== want.nack)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp scl=%0b sda=%0b busy=%0b done=%0b ",
                                 $realtime, want.scl, want.sda, want.busy, want.done,
                                 "rx=%02h nack=%0b", want.rx, want.nack,
                                 " / got scl=%0b sda=%0b busy=%0b done=%0b ",
                                 seen.scl, seen.sda, seen.busy, seen.done,
                                 "rx=%02h nack=%0b", seen.rx, seen.nack);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = CMD_NONE;
        write_byte     = 8'd0;
        ack_after_read = 1'b0;
        tick           = 1'b0;
        sda_in         = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = REG_HALF_PERIOD;
        cfg_data       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_reset_defaults();
        check_write_patterns();
        check_read_patterns();
        check_ack_wait();
        check_zero_half_period();
        check_max_half_period();
        check_random_traffic();

        // drain outstanding results, then idle before the verdict
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
